>>> rtl/gsf_pkg.sv
// ----------------------------------------------------------------------------
// gsf_pkg
// Shared types and constants of the grid spring force accumulator.
// ----------------------------------------------------------------------------
package gsf_pkg;

  localparam int GSF_GRID_WIDTH  = 32;
  localparam int GSF_GRID_HEIGHT = 32;

  localparam int PART_W    = 10;
  localparam int DATA_W    = 32;
  localparam int RLEN_W    = 31;
  localparam int ROOT_W    = 32;
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS = 1'b0,
    CFG_REST      = 1'b1
  } cfg_idx_e;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_COL1, S_COL2, S_RD_SELF, S_LD_SELF, S_NB_CHK, S_DIFF,
    S_SQ_MUL, S_SQ_ADD, S_SQRT_INIT, S_SQRT, S_CHK, S_MUL_ED, S_DIV_INIT,
    S_DIV, S_MUL_KT, S_ACC, S_NB_NEXT, S_DONE
  } gsf_state_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_WRITE, DP_LOAD, DP_COL1, DP_COL2, DP_RD_SELF, DP_LD_SELF,
    DP_RD_NB, DP_DIFF, DP_SQ_MUL, DP_SQ_ADD, DP_SQRT_INIT, DP_SQRT_STEP,
    DP_SET_ZERO, DP_ERR, DP_MUL_ED, DP_DIV_INIT, DP_DIV_STEP, DP_MUL_KT,
    DP_ACC, DP_OUT
  } gsf_op_e;

  typedef struct packed {
    gsf_op_e    op;
    logic [1:0] axis;
    logic [1:0] nb;
  } gsf_cmd_t;

  typedef struct packed {
    logic [3:0] mask;
    logic       zero;
  } gsf_status_t;

endpackage

>>> rtl/gsf_req_if.sv
// ----------------------------------------------------------------------------
// gsf_req_if
// Request channel: position writes and compute requests.
// ----------------------------------------------------------------------------
interface gsf_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [9:0]        particle;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [31:0] base_z;

  modport source (output valid, req_type, particle, pos_x, pos_y, pos_z,
                  base_x, base_y, base_z, input ready);
  modport sink (input valid, req_type, particle, pos_x, pos_y, pos_z,
                base_x, base_y, base_z, output ready);
endinterface

>>> rtl/gsf_rsp_if.sv
// ----------------------------------------------------------------------------
// gsf_rsp_if
// Response channel: accumulated acceleration and flags.
// ----------------------------------------------------------------------------
interface gsf_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  logic               zero_distance;
  logic               saturated;

  modport source (output valid, acc_x, acc_y, acc_z, zero_distance, saturated,
                  input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, zero_distance, saturated,
                output ready);
endinterface

>>> rtl/gsf_datapath.sv
// ----------------------------------------------------------------------------
// gsf_datapath
// Position memory, shared multiplier, square root and divide steps, saturation.
// ----------------------------------------------------------------------------
module gsf_datapath #(
  parameter int GRID_WIDTH  = gsf_pkg::GSF_GRID_WIDTH,
  parameter int GRID_HEIGHT = gsf_pkg::GSF_GRID_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gsf_pkg::gsf_cmd_t                 cmd_i,
  output gsf_pkg::gsf_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic [gsf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gsf_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic [gsf_pkg::PART_W-1:0]        particle_i,
  input  logic signed [gsf_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [gsf_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [gsf_pkg::DATA_W-1:0] pos_z_i,
  input  logic signed [gsf_pkg::DATA_W-1:0] base_x_i,
  input  logic signed [gsf_pkg::DATA_W-1:0] base_y_i,
  input  logic signed [gsf_pkg::DATA_W-1:0] base_z_i,
  output logic signed [gsf_pkg::DATA_W-1:0] acc_x_o,
  output logic signed [gsf_pkg::DATA_W-1:0] acc_y_o,
  output logic signed [gsf_pkg::DATA_W-1:0] acc_z_o,
  output logic                              zero_distance_o,
  output logic                              saturated_o
);
  import gsf_pkg::*;

  localparam int NUM = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW  = $clog2(NUM);
  localparam int IW  = ((AW > PART_W) ? AW : PART_W) + 1;
  localparam int RSH = 2 * PART_W;
  localparam int QW  = PART_W + RSH;
  localparam logic [RSH-1:0] RECIP = RSH'((1 << RSH) / GRID_WIDTH);
  localparam logic [IW-1:0] W_I    = IW'(GRID_WIDTH);
  localparam logic [IW-1:0] WM1_I  = IW'(GRID_WIDTH - 1);
  localparam logic [IW-1:0] NUM_I  = IW'(NUM);
  localparam logic [IW-1:0] LAST_I = IW'(NUM - GRID_WIDTH);

  function automatic logic [32:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return {1'b1, 32'h7fff_ffff};
    else if (v < -34'sd2147483648) return {1'b1, 32'h8000_0000};
    else return {1'b0, v[31:0]};
  endfunction

  function automatic logic inrange_in(input logic [PART_W-1:0] p);
    return IW'(p) < NUM_I;
  endfunction

  logic [3*DATA_W-1:0] mem [NUM];
  logic [3*DATA_W-1:0] rdata_q;
  logic [AW-1:0]       raddr;

  logic [DATA_W-1:0]        k_q;
  logic [RLEN_W-1:0]        rest_q;
  logic [PART_W-1:0]        part_q, q0_q;
  logic signed [DATA_W-1:0] acc_q [3];
  logic signed [DATA_W-1:0] self_q [3];
  logic signed [DATA_W-1:0] diff_q [3];
  logic                     zflag_q, sflag_q;
  logic [3:0]               mask_q;
  logic [65:0]              prod_q;
  logic [63:0]              sum_q, s_q;
  logic [32:0]              rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [32:0]              emag_q;
  logic                     eneg_q, tneg_q;
  logic [31:0]              dr_q;
  logic [32:0]              dq_q;

  logic [IW-1:0]    part_w, colr, col, nbaddr;
  logic [QW-1:0]    qprod;
  logic             inrange;
  logic signed [DATA_W-1:0] diff_sel, acc_sel;
  logic [DATA_W-1:0] dmag;
  logic [32:0]      mul_a, mul_b;
  logic [65:0]      mul_p;
  logic [34:0]      remsh, trial, remsub;
  logic             sq_ge;
  logic signed [32:0] e_full;
  logic [32:0]      dv_t, dv_sub;
  logic             dv_ge;
  logic [49:0]      pm;
  logic signed [33:0] pval, asum;
  logic             psat;
  logic [32:0]      acc_sat;
  logic [32:0]      dsat [3];

  assign part_w  = IW'(part_q);
  assign qprod   = QW'(part_q) * QW'(RECIP);
  assign colr    = part_w - IW'(q0_q) * W_I;
  assign col     = (colr >= W_I) ? colr - W_I : colr;
  assign inrange = part_w < NUM_I;

  always_comb begin
    unique case (cmd_i.nb)
      2'd0: nbaddr = part_w + IW'(1);
      2'd1: nbaddr = part_w - IW'(1);
      2'd2: nbaddr = part_w - W_I;
      default: nbaddr = part_w + W_I;
    endcase
  end

  assign raddr    = (cmd_i.op == DP_RD_NB) ? nbaddr[AW-1:0] : part_w[AW-1:0];
  assign diff_sel = diff_q[cmd_i.axis];
  assign acc_sel  = acc_q[cmd_i.axis];
  assign dmag     = diff_sel[DATA_W-1] ? DATA_W'(-diff_sel) : DATA_W'(diff_sel);

  always_comb begin
    case (cmd_i.op)
      DP_SQ_MUL: begin
        mul_a = 33'(dmag);
        mul_b = 33'(dmag);
      end
      DP_MUL_ED: begin
        mul_a = emag_q;
        mul_b = 33'(dmag);
      end
      DP_MUL_KT: begin
        mul_a = 33'(k_q);
        mul_b = dq_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dsat[a] = sat32($signed({{2{rdata_q[a*DATA_W+DATA_W-1]}}, rdata_q[a*DATA_W +: DATA_W]})
                    - $signed({{2{self_q[a][DATA_W-1]}}, self_q[a]}));
    end
  end

  assign remsh  = {rem_q, s_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign sq_ge  = remsh >= trial;
  assign remsub = remsh - trial;

  assign e_full = $signed({1'b0, root_q}) - $signed({2'b00, rest_q});

  assign dv_t   = {dr_q, dq_q[32]};
  assign dv_ge  = dv_t >= {1'b0, root_q};
  assign dv_sub = dv_t - {1'b0, root_q};

  assign pm = prod_q[65:16];
  always_comb begin
    psat = 1'b0;
    if (!tneg_q) begin
      if (pm > 50'd2147483647) begin
        pval = 34'sd2147483647;
        psat = 1'b1;
      end else begin
        pval = $signed({2'b00, pm[31:0]});
      end
    end else begin
      if (pm > 50'd2147483648) begin
        pval = -34'sd2147483648;
        psat = 1'b1;
      end else begin
        pval = -$signed({2'b00, pm[31:0]});
      end
    end
    asum    = $signed({{2{acc_sel[DATA_W-1]}}, acc_sel}) + pval;
    acc_sat = sat32(asum);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_WRITE && inrange_in(particle_i)) begin
      mem[AW'(particle_i)] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.op == DP_RD_SELF || cmd_i.op == DP_RD_NB) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= DATA_W'(65536);
      rest_q <= RLEN_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STIFFNESS: k_q    <= cfg_wdata_i;
        CFG_REST:      rest_q <= cfg_wdata_i[RLEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        part_q   <= particle_i;
        acc_q[0] <= base_x_i;
        acc_q[1] <= base_y_i;
        acc_q[2] <= base_z_i;
        zflag_q  <= 1'b0;
        sflag_q  <= 1'b0;
      end
      DP_COL1: q0_q <= qprod[QW-1:RSH];
      DP_COL2: begin
        mask_q[0] <= inrange && (col != WM1_I);
        mask_q[1] <= inrange && (col != '0);
        mask_q[2] <= inrange && (part_w >= W_I);
        mask_q[3] <= inrange && (part_w < LAST_I);
      end
      DP_LD_SELF: begin
        for (int a = 0; a < 3; a++) self_q[a] <= rdata_q[a*DATA_W +: DATA_W];
      end
      DP_DIFF: begin
        for (int a = 0; a < 3; a++) diff_q[a] <= dsat[a][31:0];
        if (dsat[0][32] || dsat[1][32] || dsat[2][32]) sflag_q <= 1'b1;
        sum_q <= '0;
      end
      DP_SQ_MUL, DP_MUL_KT: prod_q <= mul_p;
      DP_SQ_ADD: sum_q <= sum_q + prod_q[63:0];
      DP_SQRT_INIT: begin
        s_q    <= sum_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      DP_SQRT_STEP: begin
        s_q    <= {s_q[61:0], 2'b00};
        rem_q  <= sq_ge ? remsub[32:0] : remsh[32:0];
        root_q <= {root_q[ROOT_W-2:0], sq_ge};
      end
      DP_SET_ZERO: zflag_q <= 1'b1;
      DP_ERR: begin
        eneg_q <= e_full[32];
        emag_q <= e_full[32] ? 33'(-e_full) : 33'(e_full);
      end
      DP_MUL_ED: begin
        prod_q <= mul_p;
        tneg_q <= eneg_q ^ diff_sel[DATA_W-1];
      end
      DP_DIV_INIT: begin
        dr_q <= {1'b0, prod_q[63:33]};
        dq_q <= prod_q[32:0];
      end
      DP_DIV_STEP: begin
        dr_q <= dv_ge ? dv_sub[31:0] : dv_t[31:0];
        dq_q <= {dq_q[31:0], dv_ge};
      end
      DP_ACC: begin
        acc_q[cmd_i.axis] <= acc_sat[31:0];
        if (psat || acc_sat[32]) sflag_q <= 1'b1;
      end
      DP_OUT: begin
        acc_x_o         <= acc_q[0];
        acc_y_o         <= acc_q[1];
        acc_z_o         <= acc_q[2];
        zero_distance_o <= zflag_q;
        saturated_o     <= sflag_q;
      end
      default: ;
    endcase
  end

  assign status_o.mask = mask_q;
  assign status_o.zero = (root_q == '0);

endmodule

>>> rtl/gsf_ctrl.sv
// ----------------------------------------------------------------------------
// gsf_ctrl
// Sequencer: walks the neighbors, steps the shared units, owns the handshakes.
// ----------------------------------------------------------------------------
module gsf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_type_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  gsf_pkg::gsf_status_t status_i,
  output gsf_pkg::gsf_cmd_t    cmd_o
);
  import gsf_pkg::*;

  gsf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       axis_q, axis_d, nb_q, nb_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    nb_d        = nb_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o.op    = DP_NOP;
    cmd_o.axis  = axis_q;
    cmd_o.nb    = nb_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == REQ_WRITE) begin
            cmd_o.op = DP_WRITE;
          end else begin
            cmd_o.op = DP_LOAD;
            nb_d     = '0;
            state_d  = S_COL1;
          end
        end
      end
      S_COL1: begin
        cmd_o.op = DP_COL1;
        state_d  = S_COL2;
      end
      S_COL2: begin
        cmd_o.op = DP_COL2;
        state_d  = S_RD_SELF;
      end
      S_RD_SELF: begin
        cmd_o.op = DP_RD_SELF;
        state_d  = S_LD_SELF;
      end
      S_LD_SELF: begin
        cmd_o.op = DP_LD_SELF;
        state_d  = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (status_i.mask[nb_q]) begin
          cmd_o.op = DP_RD_NB;
          state_d  = S_DIFF;
        end else begin
          state_d = S_NB_NEXT;
        end
      end
      S_DIFF: begin
        cmd_o.op = DP_DIFF;
        axis_d   = '0;
        state_d  = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd_o.op = DP_SQ_MUL;
        state_d  = S_SQ_ADD;
      end
      S_SQ_ADD: begin
        cmd_o.op = DP_SQ_ADD;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = S_SQRT_INIT;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_SQRT_INIT: begin
        cmd_o.op = DP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = DP_SQRT_STEP;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.zero) begin
          cmd_o.op = DP_SET_ZERO;
          state_d  = S_NB_NEXT;
        end else begin
          cmd_o.op = DP_ERR;
          axis_d   = '0;
          state_d  = S_MUL_ED;
        end
      end
      S_MUL_ED: begin
        cmd_o.op = DP_MUL_ED;
        state_d  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.op = DP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_MUL_KT;
      end
      S_MUL_KT: begin
        cmd_o.op = DP_MUL_KT;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = DP_ACC;
        if (axis_q == 2'd2) begin
          state_d = S_NB_NEXT;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_MUL_ED;
        end
      end
      S_NB_NEXT: begin
        if (nb_q == 2'd3) begin
          state_d = S_DONE;
        end else begin
          nb_d    = nb_q + 2'd1;
          state_d = S_NB_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.op    = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (cnt_q < CNT_W'(ROOT_W)))
    else $error("root step count overran");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> (state_q == S_MUL_KT))
    else $error("divide did not finish on its last step");

  a_zero_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && status_i.zero) |=> (state_q == S_NB_NEXT))
    else $error("coincident neighbor was not skipped");

  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || rsp_ready_i)) |=>
    (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded when slot was free");

endmodule

>>> rtl/grid_spring_force_accumulator.sv
// ----------------------------------------------------------------------------
// grid_spring_force_accumulator
// Spring acceleration of one particle of a rectangular grid from its neighbors.
// ----------------------------------------------------------------------------
// Usage: words arrive on req_i. A write word (req_type 0) stores one particle's
// position and returns nothing. A compute word (req_type 1) returns one word on
// rsp_o: the base acceleration plus the spring terms of the right, left, below
// and above neighbors that exist, saturated Q16.16, with the zero_distance and
// saturated flags.
// Compute: for each existing neighbor a squared distance, a square root and,
// unless the neighbor coincides with the particle, a divide per axis; missing
// neighbors are skipped. The work uses one shared multiplier, a one-bit-per-cycle
// square root (32 steps) and a one-bit-per-cycle divider (33 steps per axis).
// One word is worked on at a time; req_i is ready whenever the sequencer idles,
// also while a finished result still waits in the output register.
// If rsp_o stalls, the next compute word finishes and then waits for the slot.
// Reset clears the handshakes and sets stiffness and rest length to 1.0; the
// position memory is not cleared and must be written before it is read.
// cfg_we_i writes register cfg_idx_i (0 stiffness, 1 rest length); the user must do so while idle, unchecked.
// ----------------------------------------------------------------------------
module grid_spring_force_accumulator #(
  parameter int GRID_WIDTH  = gsf_pkg::GSF_GRID_WIDTH,
  parameter int GRID_HEIGHT = gsf_pkg::GSF_GRID_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gsf_req_if.sink                       req_i,
  gsf_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [gsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gsf_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import gsf_pkg::*;

  gsf_cmd_t    cmd;
  gsf_status_t status;

  gsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gsf_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .particle_i      (req_i.particle),
    .pos_x_i         (req_i.pos_x),
    .pos_y_i         (req_i.pos_y),
    .pos_z_i         (req_i.pos_z),
    .base_x_i        (req_i.base_x),
    .base_y_i        (req_i.base_y),
    .base_z_i        (req_i.base_z),
    .acc_x_o         (rsp_o.acc_x),
    .acc_y_o         (rsp_o.acc_y),
    .acc_z_o         (rsp_o.acc_z),
    .zero_distance_o (rsp_o.zero_distance),
    .saturated_o     (rsp_o.saturated)
  );

endmodule
